### hw/rtl/pbs_pkg.sv
// shared types, constants and helpers for the pixel binning core
// no dependencies; used by every other file of the block

package pbs_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int W_BITS      = COL_BITS + 1;
   localparam int PIX_BITS    = 16;
   localparam int SUM_BITS    = PIX_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;
   localparam int MAX_LOG2    = 2;

   localparam logic [SUM_BITS-1:0] SAT_MARK = SUM_BITS'(1) << PIX_BITS;

   // csr map
   localparam int ADDR_BITS = 4;
   localparam logic [1:0] REG_BIN_X     = 2'd0;
   localparam logic [1:0] REG_BIN_Y     = 2'd1;
   localparam logic [1:0] REG_ROW_WIDTH = 2'd2;
   localparam int ROW_WIDTH_BITS = 13;
   localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(4096);

   // derived configuration handed to the front end
   typedef struct packed {
      logic [1:0]        lx;
      logic [1:0]        x_top;     // last horizontal phase
      logic [1:0]        y_top;     // last vertical phase
      logic [W_BITS-1:0] w;         // effective row width
      logic [W_BITS-1:0] usable;    // pixels covered by full bins
      logic [W_BITS-1:0] nb_last;   // index of last output column
   } cfg_type;

   // one column update from front to back
   typedef struct packed {
      logic [COL_BITS-1:0] oc;
      logic [SUM_BITS-1:0] acc;
      logic                first;
      logic                last;
      logic                row_end;
   } op_type;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = (s > {1'b0, SAT_MARK}) ? SAT_MARK : s[SUM_BITS-1:0];
   endfunction

endpackage

### hw/rtl/pbs_if.sv
// valid/ready channel interfaces for pixels in and binned pixels out
// depends on pbs_pkg

interface pbs_req_if;
   logic                         valid;
   logic                         ready;
   logic [pbs_pkg::PIX_BITS-1:0] pixel;
   logic                         frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface pbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [pbs_pkg::PIX_BITS-1:0] binned_pixel;
   logic                         row_end;
   logic                         clamped;

   modport source (output valid, output binned_pixel, output row_end, output clamped,
                   input ready);
   modport sink   (input valid, input binned_pixel, input row_end, input clamped,
                   output ready);
endinterface

### hw/rtl/pbs_front.sv
// front end: accepts pixels, tracks row and bin phases, sums horizontally
// depends on pbs_pkg and pbs_req_if; pushes column updates into the queue

module pbs_front (
   input  logic                clock,
   input  logic                reset,
   pbs_req_if.sink             req,
   input  pbs_pkg::cfg_type    cfg,
   input  logic                q_full,
   output logic                push,
   output pbs_pkg::op_type     push_op
);

   logic [pbs_pkg::COL_BITS-1:0] ci_ff, ci_in, ci;
   logic [1:0]                   xp_ff, xp_in, xp;
   logic [1:0]                   yp_ff, yp_in, yp;
   logic [pbs_pkg::SUM_BITS-1:0] acc_ff, acc_in, acc, acc_new;
   logic [pbs_pkg::W_BITS-1:0]   ci_next;
   logic                         accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      ci  = req.frame_start ? '0 : ci_ff;
      xp  = req.frame_start ? '0 : xp_ff;
      yp  = req.frame_start ? '0 : yp_ff;
      acc = req.frame_start ? '0 : acc_ff;
      if ({1'b0, ci} >= cfg.w) begin
         ci = '0;
      end

      acc_new = pbs_pkg::sat_add((xp == 2'd0) ? '0 : acc,
                                 pbs_pkg::SUM_BITS'(req.pixel));
      ci_next = {1'b0, ci} + pbs_pkg::W_BITS'(1);

      ci_in   = ci_ff;
      xp_in   = xp_ff;
      yp_in   = yp_ff;
      acc_in  = acc_ff;
      push    = 1'b0;
      push_op.oc      = ci >> cfg.lx;
      push_op.acc     = acc_new;
      push_op.first   = (yp == 2'd0);
      push_op.last    = (yp >= cfg.y_top);
      push_op.row_end = ({1'b0, push_op.oc} == cfg.nb_last);

      if (accept) begin
         acc_in = acc;
         xp_in  = xp;
         yp_in  = yp;
         if ({1'b0, ci} < cfg.usable) begin
            acc_in = acc_new;
            if (xp >= cfg.x_top) begin
               push  = 1'b1;
               xp_in = 2'd0;
            end else begin
               xp_in = xp + 2'd1;
            end
         end
         // end of source row
         if (ci_next >= cfg.w) begin
            ci_in = '0;
            xp_in = 2'd0;
            yp_in = (yp >= cfg.y_top) ? 2'd0 : yp + 2'd1;
         end else begin
            ci_in = ci_next[pbs_pkg::COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff  <= '0;
         xp_ff  <= '0;
         yp_ff  <= '0;
         acc_ff <= '0;
      end else begin
         ci_ff  <= ci_in;
         xp_ff  <= xp_in;
         yp_ff  <= yp_in;
         acc_ff <= acc_in;
      end
   end

endmodule

### hw/rtl/pbs_queue.sv
// short fifo of column updates between front and back end
// depends on pbs_pkg

module pbs_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pbs_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output pbs_pkg::op_type head_op
);

   pbs_pkg::op_type               entry_ff [pbs_pkg::QUEUE_DEPTH];
   logic [pbs_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pbs_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pbs_pkg::QCNT_BITS-1:0] count_ff, count_in;

   assign full       = (count_ff == pbs_pkg::QCNT_BITS'(pbs_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pbs_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + pbs_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + pbs_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - pbs_pkg::QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### hw/rtl/pbs_back.sv
// back end: line store of partial column sums, vertical add, output register
// depends on pbs_pkg and pbs_rsp_if; pops column updates from the queue

module pbs_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  pbs_pkg::op_type head_op,
   output logic            pop,
   pbs_rsp_if.source       rsp
);

   logic [pbs_pkg::SUM_BITS-1:0] line_mem [pbs_pkg::MAX_WIDTH];

   pbs_pkg::op_type              b_op_ff;
   logic                         b_valid_ff, b_valid_in;
   logic [pbs_pkg::SUM_BITS-1:0] rdata_ff;

   // bypass of the latest line store write
   logic                         fwd_valid_ff;
   logic [pbs_pkg::COL_BITS-1:0] fwd_addr_ff;
   logic [pbs_pkg::SUM_BITS-1:0] fwd_data_ff;

   logic                         out_valid_ff, out_valid_in;
   logic [pbs_pkg::PIX_BITS-1:0] out_pixel_ff;
   logic                         out_row_end_ff, out_clamped_ff;

   logic [pbs_pkg::SUM_BITS-1:0] prev, sum;
   logic                         out_free, b_fire, wr_en;

   always_comb begin
      prev     = (fwd_valid_ff && fwd_addr_ff == b_op_ff.oc) ? fwd_data_ff : rdata_ff;
      sum      = pbs_pkg::sat_add(b_op_ff.first ? '0 : prev, b_op_ff.acc);
      out_free = !out_valid_ff || rsp.ready;
      b_fire   = b_valid_ff && (!b_op_ff.last || out_free);
      wr_en    = b_fire && !b_op_ff.last;
      pop      = head_valid && (!b_valid_ff || b_fire);
      b_valid_in = pop ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
      out_valid_in = out_valid_ff;
      if (b_fire && b_op_ff.last) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_op_ff  <= head_op;
         rdata_ff <= line_mem[head_op.oc];
      end
      if (wr_en) begin
         line_mem[b_op_ff.oc] <= sum;
         fwd_addr_ff          <= b_op_ff.oc;
         fwd_data_ff          <= sum;
      end
      if (b_fire && b_op_ff.last) begin
         out_pixel_ff   <= sum[pbs_pkg::SUM_BITS-1] ? '1 : sum[pbs_pkg::PIX_BITS-1:0];
         out_clamped_ff <= sum[pbs_pkg::SUM_BITS-1];
         out_row_end_ff <= b_op_ff.row_end;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.binned_pixel = out_pixel_ff;
   assign rsp.row_end      = out_row_end_ff;
   assign rsp.clamped      = out_clamped_ff;

endmodule

### hw/rtl/pixel_binning_saturating_core.sv
// top level: 2d pixel binning with saturating sums, csr block and datapath
// result path: queue entry, back-end op register, then output register
// throughput: one pixel per cycle unless stalled (one line store read, one write)
// stalls: a held result backs up the back end, then the 4-entry queue, then the input
// reset: synchronous; clears phases, queue and output; line store is not cleared
// depends on pbs_pkg, pbs_if, pbs_front, pbs_queue, pbs_back

module pixel_binning_saturating_core (
   input  logic                          clock,
   input  logic                          reset,
   pbs_req_if.sink                       req,
   pbs_rsp_if.source                     rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pbs_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   // configuration registers
   logic [1:0]                            bin_x_ff;
   logic [1:0]                            bin_y_ff;
   logic [pbs_pkg::ROW_WIDTH_BITS-1:0]    row_width_ff;
   logic [1:0]                            reg_index;
   logic                                  csr_wr;

   pbs_pkg::cfg_type cfg;
   logic [31:0]      rw32;
   logic [pbs_pkg::W_BITS-1:0] nb;

   logic            push, pop, q_full, head_valid;
   pbs_pkg::op_type push_op, head_op;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_x_ff     <= '0;
         bin_y_ff     <= '0;
         row_width_ff <= pbs_pkg::ROW_WIDTH_RESET;
      end else if (csr_wr) begin
         unique case (reg_index)
            pbs_pkg::REG_BIN_X:     bin_x_ff     <= csr_pwdata[1:0];
            pbs_pkg::REG_BIN_Y:     bin_y_ff     <= csr_pwdata[1:0];
            pbs_pkg::REG_ROW_WIDTH: row_width_ff <= csr_pwdata[pbs_pkg::ROW_WIDTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (reg_index)
         pbs_pkg::REG_BIN_X:     csr_prdata = 32'(bin_x_ff);
         pbs_pkg::REG_BIN_Y:     csr_prdata = 32'(bin_y_ff);
         pbs_pkg::REG_ROW_WIDTH: csr_prdata = 32'(row_width_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // effective factors and row width; factor code 3 acts as 4, width clamped
   always_comb begin
      cfg.lx = (bin_x_ff > 2'(pbs_pkg::MAX_LOG2)) ? 2'(pbs_pkg::MAX_LOG2) : bin_x_ff;
      cfg.x_top = 2'((3'd1 << cfg.lx) - 3'd1);
      cfg.y_top = (bin_y_ff >= 2'(pbs_pkg::MAX_LOG2)) ? 2'd3
                : 2'((3'd1 << bin_y_ff) - 3'd1);
      rw32 = 32'(row_width_ff);
      if (rw32 == 32'd0) begin
         cfg.w = pbs_pkg::W_BITS'(1);
      end else if (rw32 > 32'(pbs_pkg::MAX_WIDTH)) begin
         cfg.w = pbs_pkg::W_BITS'(pbs_pkg::MAX_WIDTH);
      end else begin
         cfg.w = pbs_pkg::W_BITS'(rw32);
      end
      nb          = cfg.w >> cfg.lx;
      cfg.usable  = nb << cfg.lx;
      // wraps to all ones when no full bin fits, so no column ever matches
      cfg.nb_last = nb - pbs_pkg::W_BITS'(1);
   end

   // front end: phases and horizontal sums
   pbs_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .cfg     (cfg),
      .q_full  (q_full),
      .push    (push),
      .push_op (push_op)
   );

   // decoupling queue of column updates
   pbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   // back end: line store and result transfer
   pbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

### bench/tb_pixel_binning_saturating_core.sv
// self-checking bench for pixel_binning_saturating_core: pixel stream in, binned pixels out
// depends on pbs_pkg, pbs_if and the core; no files or arguments needed

`timescale 1ns / 100ps

module tb_pixel_binning_saturating_core;

   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to fill the core
   localparam int SETTLE_CYCLES = 8;     // margin for results still in flight
   localparam int QUIET_LIMIT   = 4000;  // cycles without any transfer before giving up
   localparam int RANDOM_ITEMS  = 1200;

   typedef struct packed {
      logic [pbs_pkg::PIX_BITS-1:0] pixel;
      logic                         frame_start;
   } pixel_item_type;

   typedef struct packed {
      logic [pbs_pkg::PIX_BITS-1:0] binned_pixel;
      logic                         row_end;
      logic                         clamped;
   } binned_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [pbs_pkg::ADDR_BITS-1:0] csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   pbs_req_if req_if ();
   pbs_rsp_if rsp_if ();

   pixel_binning_saturating_core dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // pixels waiting to be offered and binned pixels still owed by the core
   pixel_item_type pending_pixels[$];
   binned_type     expected_bins[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   logic want_hold   = 1'b0;

   // shadow of the register file
   logic [1:0]                         bin_x_code = 2'd0;
   logic [1:0]                         bin_y_code = 2'd0;
   logic [pbs_pkg::ROW_WIDTH_BITS-1:0] width_code = pbs_pkg::ROW_WIDTH_RESET;

   // shadow of the binning state
   logic [pbs_pkg::SUM_BITS-1:0] row_partial;
   logic [pbs_pkg::SUM_BITS-1:0] column_partial [pbs_pkg::MAX_WIDTH];
   int unsigned                  pixel_col;
   int unsigned                  x_pos;
   int unsigned                  y_pos;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // binning arithmetic as the core should see it
   // ------------------------------------------------------------------

   // unsigned add that sticks at 65536, the marker for "already clamped"
   function automatic logic [pbs_pkg::SUM_BITS-1:0] saturating_sum(
         input logic [pbs_pkg::SUM_BITS-1:0] a,
         input logic [pbs_pkg::SUM_BITS-1:0] b);
      int unsigned total;
      total = int'(a) + int'(b);
      return (total > 65536) ? pbs_pkg::SUM_BITS'(65536) : pbs_pkg::SUM_BITS'(total);
   endfunction

   function automatic int unsigned factor_log2(input logic [1:0] code);
      return (code > 2'd2) ? 2 : int'(code);
   endfunction

   // row width as the core applies it: zero counts as one, capped at the line store
   function automatic int unsigned active_width();
      if (width_code == 0)
         return 1;
      if (width_code > pbs_pkg::MAX_WIDTH)
         return pbs_pkg::MAX_WIDTH;
      return int'(width_code);
   endfunction

   // advance the shadow state by one transferred pixel, queue a binned pixel if a block closes
   task automatic bin_pixel(input logic [pbs_pkg::PIX_BITS-1:0] pix, input logic frame_start);
      int unsigned                  lx;
      int unsigned                  bx;
      int unsigned                  by;
      int unsigned                  w;
      int unsigned                  nb;
      int unsigned                  oc;
      logic [pbs_pkg::SUM_BITS-1:0] block_sum;
      binned_type                   result;
      lx = factor_log2(bin_x_code);
      bx = 1 << lx;
      by = 1 << factor_log2(bin_y_code);
      w  = active_width();
      nb = w >> lx;
      if (frame_start) begin
         pixel_col   = 0;
         x_pos       = 0;
         y_pos       = 0;
         row_partial = '0;
      end
      if (pixel_col >= w)
         pixel_col = 0;
      // trailing pixels past the last full bin are dropped
      if (pixel_col < (nb << lx)) begin
         row_partial = saturating_sum((x_pos == 0) ? '0 : row_partial,
                                      pbs_pkg::SUM_BITS'(pix));
         if (x_pos >= bx - 1) begin
            oc = (pixel_col >> lx) % pbs_pkg::MAX_WIDTH;
            block_sum = saturating_sum((y_pos == 0) ? '0 : column_partial[oc], row_partial);
            if (y_pos >= by - 1) begin
               result.clamped      = (block_sum > 65535);
               result.binned_pixel = result.clamped ? 16'hFFFF
                                   : block_sum[pbs_pkg::PIX_BITS-1:0];
               result.row_end      = (oc == nb - 1);
               expected_bins.push_back(result);
            end else begin
               column_partial[oc] = block_sum;
            end
            x_pos = 0;
         end else begin
            x_pos = (x_pos + 1) & 3;
         end
      end
      pixel_col++;
      if (pixel_col >= w) begin
         pixel_col = 0;
         x_pos     = 0;
         y_pos     = (y_pos >= by - 1) ? 0 : ((y_pos + 1) & 3);
      end
   endtask

   // ------------------------------------------------------------------
   // pixel driver: offers queued pixels, predicts on every transfer
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_pixels
      pixel_item_type item;
      if (reset) begin
         req_if.valid       <= 1'b0;
         req_if.pixel       <= '0;
         req_if.frame_start <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            bin_pixel(req_if.pixel, req_if.frame_start);
         // a new pixel may go out once the current one has transferred
         if (!req_if.valid || req_if.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_pixels.pop_front();
               req_if.valid       <= 1'b1;
               req_if.pixel       <= item.pixel;
               req_if.frame_start <= item.frame_start;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result side: random back-pressure plus one long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_ready
      int hold_left;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
      end else if (want_hold) begin
         rsp_if.ready <= 1'b0;
         hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // every binned pixel transfer is checked against the oldest prediction
   always @(posedge clock) begin : check_bins
      binned_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_bins.size() == 0) begin
            $error("binned pixel %0d arrived with none expected", rsp_if.binned_pixel);
            error_count++;
         end else begin
            want = expected_bins.pop_front();
            if (rsp_if.binned_pixel !== want.binned_pixel) begin
               $error("binned_pixel expected %0d got %0d", want.binned_pixel,
                      rsp_if.binned_pixel);
               error_count++;
            end
            if (rsp_if.row_end !== want.row_end) begin
               $error("row_end expected %0d got %0d", want.row_end, rsp_if.row_end);
               error_count++;
            end
            if (rsp_if.clamped !== want.clamped) begin
               $error("clamped expected %0d got %0d", want.clamped, rsp_if.clamped);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer on either channel
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // apb write: setup cycle, then access cycle; the register takes it at the access edge
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= pbs_pkg::ADDR_BITS'({index, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         pbs_pkg::REG_BIN_X:     bin_x_code = value[1:0];
         pbs_pkg::REG_BIN_Y:     bin_y_code = value[1:0];
         pbs_pkg::REG_ROW_WIDTH: width_code = value[pbs_pkg::ROW_WIDTH_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [1:0] bx_code, input logic [1:0] by_code,
                            input int width);
      write_register(pbs_pkg::REG_BIN_X, 32'(bx_code));
      write_register(pbs_pkg::REG_BIN_Y, 32'(by_code));
      write_register(pbs_pkg::REG_ROW_WIDTH, 32'(width));
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 76; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 76; end
         IDLE_BOTH:     begin send_idle_pct = 38; stall_pct = 38; end
      endcase
   endtask

   task automatic push_pixel(input logic [pbs_pkg::PIX_BITS-1:0] pix, input logic frame_start);
      pending_pixels.push_back('{pixel: pix, frame_start: frame_start});
   endtask

   // mix of full range, near full scale (to clamp) and dark values
   function automatic logic [pbs_pkg::PIX_BITS-1:0] random_pixel();
      case ($urandom_range(3))
         0:       return pbs_pkg::PIX_BITS'($urandom_range(65535));
         1:       return pbs_pkg::PIX_BITS'($urandom_range(65535, 60000));
         2:       return pbs_pkg::PIX_BITS'($urandom_range(255));
         default: return 16'hFFFF;
      endcase
   endfunction

   // one frame in raster order, with the odd stray frame start as noise
   task automatic queue_frame(input int rows, input int extra, output int count);
      count = rows * active_width() + extra;
      for (int i = 0; i < count; i++)
         push_pixel(random_pixel(), (i == 0) || ($urandom_range(99) < 2));
   endtask

   // all pixels transferred, all bins seen, then room for any in-flight trailing pixel
   task automatic wait_drained();
      while (pending_pixels.size() != 0 || req_if.valid || expected_bins.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : run_test
      int sent;
      int count;
      int phase;
      int w;
      int by_rows;
      logic [1:0] bx_code;
      logic [1:0] by_code;

      req_if.valid       = 1'b0;
      req_if.pixel       = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready       = 1'b0;
      row_partial = '0;
      pixel_col   = 0;
      x_pos       = 0;
      y_pos       = 0;
      for (int i = 0; i < pbs_pkg::MAX_WIDTH; i++)
         column_partial[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings (1x1, full width): pixel extremes, frame start mid-row
      set_idling(IDLE_NONE);
      push_pixel(16'h0000, 1'b1);
      push_pixel(16'hFFFF, 1'b0);
      push_pixel(16'h5555, 1'b0);
      push_pixel(16'hAAAA, 1'b1);
      wait_drained();

      // factor code 3 acts as 4, width zero acts as 1: every pixel is trailing
      configure(2'd3, 2'd1, 0);
      push_pixel(16'h1234, 1'b1);
      push_pixel(16'hFFFF, 1'b0);
      wait_drained();

      // 4x2 bins on a 9-wide row: one clamped block, one plain, trailing column dropped
      configure(2'd2, 2'd1, 9);
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 9; c++) begin
            if (c < 4)
               push_pixel((r == 0) ? 16'hFFFF : 16'h0000, (r == 0) && (c == 0));
            else if (c < 8)
               push_pixel((r == 0) ? pbs_pkg::PIX_BITS'(c - 3) : 16'd10, 1'b0);
            else
               push_pixel(16'hFFFF, 1'b0);
         end
      end
      // stop mid-bin, then shrink the factors without a frame start
      push_pixel(16'd100, 1'b0);
      push_pixel(16'd200, 1'b0);
      wait_drained();
      configure(2'd0, 2'd0, 13'h1FFF);   // width above the line store clamps to it
      push_pixel(16'd300, 1'b0);
      push_pixel(16'd400, 1'b0);
      wait_drained();

      // a stretch of a row at the widest setting
      configure(2'd2, 2'd0, pbs_pkg::MAX_WIDTH);
      for (int i = 0; i < 259; i++)
         push_pixel(random_pixel(), i == 0);
      wait_drained();

      // receiver holds off while the sender keeps offering, so the core backs up
      configure(2'd0, 2'd0, 16);
      for (int i = 0; i < 120; i++)
         push_pixel(random_pixel(), i == 0);
      @(posedge clock);
      want_hold <= 1'b1;
      @(posedge clock);
      want_hold <= 1'b0;
      wait_drained();

      // random frames, cycling through the idling patterns
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         bx_code = 2'($urandom_range(3));
         by_code = 2'($urandom_range(3));
         case ($urandom_range(15))
            0:       w = 0;
            1:       w = $urandom_range(200, 25);
            default: w = $urandom_range(24, 1);
         endcase
         configure(bx_code, by_code, w);
         set_idling(idle_mode_type'(phase % 4));
         by_rows = 1 << factor_log2(by_code);
         if (active_width() > 24)
            queue_frame(by_rows, $urandom_range(active_width() - 1), count);
         else
            queue_frame(by_rows * $urandom_range(3, 1), $urandom_range(active_width() - 1),
                        count);
         sent += count;
         phase++;
         wait_drained();
      end

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
